FILE: src/pef_pkg.sv
`default_nettype none

package pef_pkg;

  // geometry defaults
  localparam int MAX_WIDTH_DEF = 1024;

  // field and counter widths
  localparam int PIX_W   = 8;
  localparam int FW_W    = 11;
  localparam int HGT_W   = 16;
  localparam int ROW_W   = HGT_W + 1;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int SUM_W   = PIX_W + 2;

  // register reset values
  localparam logic [FW_W-1:0]  WIDTH_RST  = FW_W'(640);
  localparam logic [HGT_W-1:0] HEIGHT_RST = HGT_W'(480);

  // command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // register indexes (paddr word offset)
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_TRANSPOSE    = 2'd2;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // per-advance control passed from the position stage to the compute stage
  typedef struct packed {
    logic have;
    logic m_left;
    logic m_right;
    logic m_top;
    logic m_bot;
    logic last;
  } adv_ctl_t;

  // one result entry
  typedef struct packed {
    logic [PIX_W-1:0] result_pixel;
    logic             last_of_frame;
  } res_t;

endpackage

`default_nettype wire

FILE: src/pef_pix_if.sv
`default_nettype none

interface pef_pix_if;
  import pef_pkg::*;

  logic             valid;
  logic             ready;
  logic             cmd;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output cmd, output pixel, input ready);
  modport sink   (input valid, input cmd, input pixel, output ready);

endinterface

`default_nettype wire

FILE: src/pef_res_if.sv
`default_nettype none

interface pef_res_if;
  import pef_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] result_pixel;
  logic             last_of_frame;

  modport source (output valid, output result_pixel, output last_of_frame, input ready);
  modport sink   (input valid, input result_pixel, input last_of_frame, output ready);

endinterface

`default_nettype wire

FILE: src/pef_ram.sv
`default_nettype none

module pef_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // single write port, registered read (old data on same-address collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[raddr];
  end

  assign rdata = rd_data_r;

endmodule

`default_nettype wire

FILE: src/prewitt_edge_filter_3x3_unit.sv
`default_nettype none
// Results pass through the stage-two registers into a three-entry output queue.
// Throughput: one item per cycle while the queue has room; line memory is read in the
// transfer cycle, written back in the next, and forwarded on a same-column collision.
// A single-row frame inserts one internal advance (one cycle of in ready low) at frame end.
// Reset: positions, drain count, window and output queue clear; line memory is not cleared.
module prewitt_edge_filter_3x3_unit #(
  parameter int MAX_WIDTH = pef_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  pef_pix_if.sink                          in_if,
  pef_res_if.source                        out_if,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pef_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [pef_pkg::DATA_W-1:0]  pwdata,
  output logic      [pef_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);
  import pef_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int PW   = $clog2(MAX_WIDTH + 2);
  localparam int LN_W = 2 * PIX_W;

  // ---------------- configuration registers ----------------
  logic [FW_W-1:0]  frame_width_r;
  logic [HGT_W-1:0] frame_height_r;
  logic             transpose_r;
  logic             cfg_wr;
  logic             cfg_geo_wr;
  logic [1:0]       cfg_idx;

  assign pready     = 1'b1;
  assign cfg_idx    = paddr[3:2];
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign cfg_geo_wr = cfg_wr && (cfg_idx == REG_FRAME_WIDTH || cfg_idx == REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RST;
      frame_height_r <= HEIGHT_RST;
      transpose_r    <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FRAME_WIDTH:  frame_width_r  <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= pwdata[HGT_W-1:0];
        REG_TRANSPOSE:    transpose_r    <= pwdata[0];
        default:          ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_r);
      REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_r);
      REG_TRANSPOSE:    prdata = DATA_W'(transpose_r);
      default:          prdata = '0;
    endcase
  end

  // effective geometry
  logic [WW-1:0]    w_eff;
  logic [HGT_W-1:0] h_eff;
  logic [ROW_W-1:0] h_row;
  logic             h_one;

  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width_r);
    end
  end

  assign h_eff = (frame_height_r == '0) ? HGT_W'(1) : frame_height_r;
  assign h_row = ROW_W'(h_eff);
  assign h_one = (h_eff == HGT_W'(1));

  // ---------------- position stage ----------------
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [PW-1:0]    pend_r, pend_nxt;
  logic             extra_r, extra_nxt;

  logic             s2_v_r;
  logic [1:0]       q_cnt_r;
  logic             acc, adv_pix, adv_drn, adv;
  logic             col_zero, wrap;
  logic [CW-1:0]    col_adv;
  logic [ROW_W-1:0] row_adv;
  adv_ctl_t         ctl;

  assign in_if.ready = !extra_r && (({1'b0, q_cnt_r} + 3'(s2_v_r)) <= 3'd2);
  assign acc     = in_if.valid && in_if.ready;
  assign adv_pix = acc && (in_if.cmd == CMD_PIXEL) && (pend_r == '0);
  assign adv_drn = acc && (in_if.cmd == CMD_DRAIN) && (pend_r != '0);
  assign adv     = adv_pix || adv_drn || extra_r;

  // output position and edge masks of the advance at (col, row)
  assign col_zero    = (col_r == '0);
  assign ctl.have    = col_zero ? (row_r >= ROW_W'(2)) : (row_r >= ROW_W'(1));
  assign ctl.m_left  = col_zero ? (w_eff == WW'(1)) : (col_r == CW'(1));
  assign ctl.m_right = col_zero;
  assign ctl.m_top   = col_zero ? (row_r == ROW_W'(2)) : (row_r == ROW_W'(1));
  assign ctl.m_bot   = col_zero ? (row_r >= h_row + ROW_W'(1)) : (row_r >= h_row);
  assign ctl.last    = col_zero && (row_r == h_row + ROW_W'(1));

  // raster advance
  assign wrap    = (WW'(col_r) + WW'(1)) >= w_eff;
  assign col_adv = wrap ? '0 : col_r + CW'(1);
  assign row_adv = wrap ? row_r + ROW_W'(1) : row_r;

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    pend_nxt  = pend_r;
    extra_nxt = extra_r;
    if (cfg_geo_wr) begin
      col_nxt   = '0;
      row_nxt   = '0;
      pend_nxt  = '0;
      extra_nxt = 1'b0;
    end else if (adv) begin
      col_nxt = col_adv;
      row_nxt = row_adv;
      if (extra_r) begin
        extra_nxt = 1'b0;
      end
      // frame end: arm the drain count
      if (adv_pix && wrap && (row_adv >= h_row)) begin
        pend_nxt  = h_one ? PW'(w_eff) : PW'(w_eff) + PW'(1);
        extra_nxt = h_one;
      end
      if (adv_drn) begin
        pend_nxt = pend_r - PW'(1);
        if (pend_r == PW'(1)) begin
          col_nxt = '0;
          row_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      pend_r  <= '0;
      extra_r <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      pend_r  <= pend_nxt;
      extra_r <= extra_nxt;
    end
  end

  // ---------------- line memory ----------------
  logic [CW-1:0]    s2_addr_r;
  logic [PIX_W-1:0] s2_pix_r;
  adv_ctl_t         s2_ctl_r;
  logic             fwd_v_r;
  logic [LN_W-1:0]  fwd_data_r;
  logic [LN_W-1:0]  ram_rdata;
  logic [LN_W-1:0]  line_rd;
  logic [LN_W-1:0]  line_wr;
  logic [PIX_W-1:0] up_px, mid_px;

  pef_ram #(
    .WIDTH (LN_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s2_v_r),
    .waddr (s2_addr_r),
    .wdata (line_wr),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  // forward a write-back that collides with the read of the next advance
  assign line_rd = fwd_v_r ? fwd_data_r : ram_rdata;
  assign up_px   = line_rd[LN_W-1:PIX_W];
  assign mid_px  = line_rd[PIX_W-1:0];
  assign line_wr = {mid_px, s2_pix_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      s2_v_r  <= adv;
      fwd_v_r <= adv && s2_v_r && (s2_addr_r == col_r);
    end
  end

  always_ff @(posedge clk) begin
    s2_addr_r  <= col_r;
    s2_pix_r   <= adv_pix ? in_if.pixel : '0;
    s2_ctl_r   <= ctl;
    fwd_data_r <= line_wr;
  end

  // ---------------- window and kernel ----------------
  logic [PIX_W-1:0] win_r [6];
  logic [PIX_W-1:0] nb [3];
  logic [PIX_W-1:0] a [3][3];
  logic [SUM_W-1:0] pos_sum, neg_sum;
  logic [SUM_W:0]   diff;
  res_t             res;

  assign nb[0] = up_px;
  assign nb[1] = mid_px;
  assign nb[2] = s2_pix_r;

  // masked neighborhood, out-of-frame neighbors read as zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a[i][0] = win_r[i];
      a[i][1] = win_r[3 + i];
      a[i][2] = nb[i];
    end
    for (int i = 0; i < 3; i++) begin
      if (s2_ctl_r.m_left)  a[i][0] = '0;
      if (s2_ctl_r.m_right) a[i][2] = '0;
      if (s2_ctl_r.m_top)   a[0][i] = '0;
      if (s2_ctl_r.m_bot)   a[2][i] = '0;
    end
  end

  // row kernel: bottom minus top; transpose: right minus left
  always_comb begin
    if (transpose_r) begin
      pos_sum = SUM_W'(a[0][2]) + SUM_W'(a[1][2]) + SUM_W'(a[2][2]);
      neg_sum = SUM_W'(a[0][0]) + SUM_W'(a[1][0]) + SUM_W'(a[2][0]);
    end else begin
      pos_sum = SUM_W'(a[2][0]) + SUM_W'(a[2][1]) + SUM_W'(a[2][2]);
      neg_sum = SUM_W'(a[0][0]) + SUM_W'(a[0][1]) + SUM_W'(a[0][2]);
    end
    diff = {1'b0, pos_sum} - {1'b0, neg_sum};
    if (diff[SUM_W]) begin
      res.result_pixel = '0;
    end else if (diff > (SUM_W + 1)'(PIX_MAX)) begin
      res.result_pixel = PIX_MAX;
    end else begin
      res.result_pixel = diff[PIX_W-1:0];
    end
    res.last_of_frame = s2_ctl_r.last;
  end

  // window shift, one column per advance
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_geo_wr) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s2_v_r) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i]     <= win_r[3 + i];
        win_r[3 + i] <= nb[i];
      end
    end
  end

  // ---------------- output queue ----------------
  res_t       q_r [3];
  res_t       q_nxt [3];
  logic [1:0] q_cnt_nxt;
  logic [1:0] q_wr_idx;
  logic       push, pop;

  assign push     = s2_v_r && s2_ctl_r.have;
  assign pop      = out_if.valid && out_if.ready;
  assign q_wr_idx = q_cnt_r - 2'(pop);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (pop) begin
      q_nxt[0] = q_r[1];
      q_nxt[1] = q_r[2];
    end
    if (push) begin
      q_nxt[q_wr_idx] = res;
    end
    q_cnt_nxt = q_cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign out_if.valid         = (q_cnt_r != '0);
  assign out_if.result_pixel  = q_r[0].result_pixel;
  assign out_if.last_of_frame = q_r[0].last_of_frame;

  // ---------------- assertions ----------------
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> (q_cnt_r != 2'd3))
    else $error("output queue overflow");

  a_extra_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    extra_r |=> !extra_r)
    else $error("single-row internal advance longer than one cycle");

  a_extra_has_drain: assert property (@(posedge clk) disable iff (!rst_n)
    extra_r |-> (pend_r != '0))
    else $error("internal advance without pending drain");

  a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_v_r |-> ($past(s2_v_r) && s2_v_r))
    else $error("forwarding without a colliding write-back");

endmodule

`default_nettype wire
